// ----- sv/cir_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and helpers of the cheapest-insertion route unit.
package cir_pkg;

    // Sizing
    localparam int MAX_NODES = 64;
    localparam int MAX_ROUTE = 256;
    localparam int TIME_W    = 32;

    // Beat field widths
    localparam int ACTION_W  = 2;
    localparam int NODE_ID_W = 6;
    localparam int TRAVEL_W  = 32;
    localparam int STATUS_W  = 2;
    localparam int POS_W     = 8;
    localparam int COST_W    = 34;
    localparam int LEN_W     = 9;

    // Derived widths
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int ROUTE_AW  = $clog2(MAX_ROUTE);
    localparam int CNT_W     = $clog2(MAX_ROUTE + 1);
    localparam int MAT_DEPTH = MAX_NODES * MAX_NODES;
    localparam int MAT_AW    = $clog2(MAT_DEPTH);
    localparam int INC_W     = TIME_W + 2;
    localparam int SAT_W     = (INC_W > COST_W) ? INC_W : COST_W;

    typedef logic [ACTION_W-1:0]     action_t;
    typedef logic [STATUS_W-1:0]     status_t;
    typedef logic [NODE_ID_W-1:0]    node_id_t;
    typedef logic [NODE_W-1:0]       node_idx_t;
    typedef logic [TIME_W-1:0]       time_t;
    typedef logic [MAT_AW-1:0]       mat_addr_t;
    typedef logic [ROUTE_AW-1:0]     route_addr_t;
    typedef logic [CNT_W-1:0]        count_t;
    typedef logic signed [INC_W-1:0] inc_t;

    // Actions
    localparam action_t ACT_WRITE  = 2'd0;
    localparam action_t ACT_CLEAR  = 2'd1;
    localparam action_t ACT_APPEND = 2'd2;
    localparam action_t ACT_INSERT = 2'd3;

    // Result status
    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_SHORT = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    // Control from the sequencer to the cost datapath
    typedef struct packed {
        logic        we;
        mat_addr_t   waddr;
        time_t       wdata;
        mat_addr_t   raddr;
        logic        load_t1;
        logic        load_sum;
        logic        eval;
        logic        first;
        logic        clear;
        route_addr_t pos;
    } cost_ctl_t;

    // Reduce a node id to a matrix row or column
    function automatic node_idx_t node_idx(input node_id_t id);
        return NODE_W'(id);
    endfunction

    // Flat matrix address of row r, column c
    function automatic mat_addr_t mat_addr(input node_idx_t r, input node_idx_t c);
        return MAT_AW'(MAT_AW'(r) * MAT_AW'(MAX_NODES)) + MAT_AW'(c);
    endfunction

    // Clamp an increase to the signed result range
    function automatic logic signed [COST_W-1:0] sat_cost(input inc_t v);
        logic signed [SAT_W-1:0] w;
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        w  = SAT_W'(v);
        hi = (SAT_W'(1) <<< (COST_W - 1)) - SAT_W'(1);
        lo = -(SAT_W'(1) <<< (COST_W - 1));
        if (w > hi)
        begin
            w = hi;
        end
        else if (w < lo)
        begin
            w = lo;
        end
        return COST_W'(w);
    endfunction

endpackage

// ----- sv/cir_if.sv -----
`timescale 1ns / 1ps
// Command and result channel interfaces of the cheapest-insertion route unit.
interface cir_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [cir_pkg::ACTION_W-1:0]  action;
    logic [cir_pkg::NODE_ID_W-1:0] from_node;
    logic [cir_pkg::NODE_ID_W-1:0] to_node;
    logic [cir_pkg::TRAVEL_W-1:0]  travel_time;
    logic [cir_pkg::NODE_ID_W-1:0] node;

    modport source (output valid, action, from_node, to_node, travel_time, node,
                    input ready);
    modport sink   (input valid, action, from_node, to_node, travel_time, node,
                    output ready);
endinterface

interface cir_res_if;
    logic                              valid;
    logic                              ready;
    logic [cir_pkg::STATUS_W-1:0]        status;
    logic [cir_pkg::POS_W-1:0]           position;
    logic signed [cir_pkg::COST_W-1:0]   cost_increase;
    logic [cir_pkg::LEN_W-1:0]           route_length;

    modport source (output valid, status, position, cost_increase, route_length,
                    input ready);
    modport sink   (input valid, status, position, cost_increase, route_length,
                    output ready);
endinterface

// ----- sv/cir_cost.sv -----
`timescale 1ns / 1ps
// Travel-time matrix memory and the insertion cost datapath with best tracking.
module cir_cost (
    input  logic                clk,
    input  cir_pkg::cost_ctl_t  ctl,
    output cir_pkg::inc_t       best,
    output cir_pkg::route_addr_t best_pos
);

    cir_pkg::time_t       mat_mem [cir_pkg::MAT_DEPTH];
    cir_pkg::time_t       rdata_reg;

    cir_pkg::time_t       t1_reg;
    cir_pkg::time_t       t1_next;
    logic [cir_pkg::TIME_W:0] sum_reg;
    logic [cir_pkg::TIME_W:0] sum_next;
    cir_pkg::inc_t        best_reg;
    cir_pkg::inc_t        best_next;
    cir_pkg::route_addr_t pos_reg;
    cir_pkg::route_addr_t pos_next;
    cir_pkg::inc_t        inc;

    // Matrix memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mat_mem[ctl.waddr] <= ctl.wdata;
        end
        rdata_reg <= mat_mem[ctl.raddr];
    end

    // Increase of the current edge: t[a][n] + t[n][b] - t[a][b]
    assign inc = $signed({1'b0, sum_reg}) - $signed({2'b00, rdata_reg});

    // Accumulate terms and keep the first strict minimum
    always_comb
    begin
        t1_next   = t1_reg;
        sum_next  = sum_reg;
        best_next = best_reg;
        pos_next  = pos_reg;
        if (ctl.load_t1)
        begin
            t1_next = rdata_reg;
        end
        if (ctl.load_sum)
        begin
            sum_next = {1'b0, t1_reg} + {1'b0, rdata_reg};
        end
        if (ctl.clear)
        begin
            best_next = '0;
            pos_next  = '0;
        end
        else if (ctl.eval && (ctl.first || (inc < best_reg)))
        begin
            best_next = inc;
            pos_next  = ctl.pos;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg   <= t1_next;
        sum_reg  <= sum_next;
        best_reg <= best_next;
        pos_reg  <= pos_next;
    end

    assign best     = best_reg;
    assign best_pos = pos_reg;

endmodule

// ----- sv/cheapest_insertion_route_unit.sv -----
`timescale 1ns / 1ps
// Cheapest-insertion route unit: sequencer, route memory and result register.
//
// Usage: commands arrive on cmd (valid/ready); each accepted beat yields exactly
// one result beat on res. Actions: write one travel-time matrix entry, clear
// the route, append a node, or insert a node into the route edge of least
// added travel time (first strict minimum wins).
// The unit works on one command at a time; cmd.ready is high only while idle.
// Write, clear, append and rejected or short inserts go from decoding straight
// to loading the result, and a new command is taken once it is loaded. An
// insert scans each route edge with three reads of the matrix memory's one
// read port plus one evaluation step, then the shift moves one route entry per
// cycle through the route memory and the node is placed.
// The result sits in an output register; a new command is accepted while it
// waits, but that command's result is held back until res.ready frees the
// register. The matrix and route memories are not cleared: a matrix entry must
// be written before an insert reads it.
// Reset (rst_n low, asynchronous) empties the route and drops any result.
module cheapest_insertion_route_unit (
    input logic          clk,
    input logic          rst_n,
    cir_cmd_if.sink      cmd,
    cir_res_if.source    res
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_LD1    = 4'd2;
    localparam logic [3:0] S_M0     = 4'd3;
    localparam logic [3:0] S_M1     = 4'd4;
    localparam logic [3:0] S_M2     = 4'd5;
    localparam logic [3:0] S_M3     = 4'd6;
    localparam logic [3:0] S_SHIFT  = 4'd7;
    localparam logic [3:0] S_PLACE  = 4'd8;
    localparam logic [3:0] S_RESP   = 4'd9;

    // Control state
    logic [3:0]           state_reg,      state_next;
    cir_pkg::count_t      count_reg,      count_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 res_valid_reg,  res_valid_next;

    // Item and working registers
    cir_pkg::action_t     act_reg,        act_next;
    cir_pkg::node_id_t    from_reg,       from_next;
    cir_pkg::node_id_t    to_reg,         to_next;
    cir_pkg::time_t       tval_reg,       tval_next;
    cir_pkg::node_id_t    node_reg,       node_next;
    cir_pkg::route_addr_t idx_reg,        idx_next;
    cir_pkg::node_id_t    a_reg,          a_next;
    cir_pkg::node_id_t    b_reg,          b_next;
    cir_pkg::count_t      j_reg,          j_next;
    cir_pkg::route_addr_t pend_addr_reg,  pend_addr_next;
    cir_pkg::status_t     stat_reg,       stat_next;

    // Result register
    cir_pkg::status_t                  res_status_reg, res_status_next;
    logic [cir_pkg::POS_W-1:0]         res_pos_reg,    res_pos_next;
    logic signed [cir_pkg::COST_W-1:0] res_cost_reg,   res_cost_next;
    logic [cir_pkg::LEN_W-1:0]         res_len_reg,    res_len_next;

    // Route memory ports
    cir_pkg::node_id_t    route_mem [cir_pkg::MAX_ROUTE];
    cir_pkg::node_id_t    rt_rdata_reg;
    logic                 rt_we;
    cir_pkg::route_addr_t rt_waddr;
    cir_pkg::node_id_t    rt_wdata;
    cir_pkg::route_addr_t rt_raddr;

    // Cost datapath
    cir_pkg::cost_ctl_t   ctl;
    cir_pkg::inc_t        best;
    cir_pkg::route_addr_t best_pos;

    cir_cost u_cost (
        .clk      (clk),
        .ctl      (ctl),
        .best     (best),
        .best_pos (best_pos)
    );

    // Route memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (rt_we)
        begin
            route_mem[rt_waddr] <= rt_wdata;
        end
        rt_rdata_reg <= route_mem[rt_raddr];
    end

    assign cmd.ready         = (state_reg == S_IDLE);
    assign res.valid         = res_valid_reg;
    assign res.status        = res_status_reg;
    assign res.position      = res_pos_reg;
    assign res.cost_increase = res_cost_reg;
    assign res.route_length  = res_len_reg;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        res_valid_next  = res_valid_reg;
        act_next        = act_reg;
        from_next       = from_reg;
        to_next         = to_reg;
        tval_next       = tval_reg;
        node_next       = node_reg;
        idx_next        = idx_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        j_next          = j_reg;
        pend_addr_next  = pend_addr_reg;
        stat_next       = stat_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_cost_next   = res_cost_reg;
        res_len_next    = res_len_reg;

        ctl       = '0;
        ctl.waddr = cir_pkg::mat_addr(cir_pkg::node_idx(from_reg),
                                      cir_pkg::node_idx(to_reg));
        ctl.wdata = tval_reg;
        ctl.pos   = idx_reg + cir_pkg::ROUTE_AW'(1);
        ctl.first = (idx_reg == '0);

        rt_raddr = '0;

        // Complete a pending shift write with last cycle's read data
        rt_we    = pend_valid_reg;
        rt_waddr = pend_addr_reg;
        rt_wdata = rt_rdata_reg;

        // Drop the result once taken
        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    act_next   = cmd.action;
                    from_next  = cmd.from_node;
                    to_next    = cmd.to_node;
                    tval_next  = cir_pkg::TIME_W'(cmd.travel_time);
                    node_next  = cmd.node;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                ctl.clear  = 1'b1;
                stat_next  = cir_pkg::ST_DONE;
                state_next = S_RESP;
                unique case (act_reg)
                    cir_pkg::ACT_WRITE:
                    begin
                        ctl.we = (32'(from_reg) < cir_pkg::MAX_NODES) &&
                                 (32'(to_reg) < cir_pkg::MAX_NODES);
                    end
                    cir_pkg::ACT_CLEAR:
                    begin
                        count_next = '0;
                    end
                    cir_pkg::ACT_APPEND:
                    begin
                        if (count_reg >= cir_pkg::CNT_W'(cir_pkg::MAX_ROUTE))
                        begin
                            stat_next = cir_pkg::ST_FULL;
                        end
                        else
                        begin
                            rt_we      = 1'b1;
                            rt_waddr   = cir_pkg::ROUTE_AW'(count_reg);
                            rt_wdata   = node_reg;
                            count_next = count_reg + cir_pkg::CNT_W'(1);
                        end
                    end
                    cir_pkg::ACT_INSERT:
                    begin
                        if (count_reg >= cir_pkg::CNT_W'(cir_pkg::MAX_ROUTE))
                        begin
                            stat_next = cir_pkg::ST_FULL;
                        end
                        else if (count_reg < cir_pkg::CNT_W'(2))
                        begin
                            stat_next = cir_pkg::ST_SHORT;
                        end
                        else
                        begin
                            rt_raddr   = '0;
                            idx_next   = '0;
                            state_next = S_LD1;
                        end
                    end
                endcase
            end
            S_LD1:
            begin
                // First node of the route arrives; fetch the second
                a_next     = rt_rdata_reg;
                rt_raddr   = idx_reg + cir_pkg::ROUTE_AW'(1);
                state_next = S_M0;
            end
            S_M0:
            begin
                b_next     = rt_rdata_reg;
                ctl.raddr  = cir_pkg::mat_addr(cir_pkg::node_idx(a_reg),
                                               cir_pkg::node_idx(node_reg));
                state_next = S_M1;
            end
            S_M1:
            begin
                ctl.load_t1 = 1'b1;
                ctl.raddr   = cir_pkg::mat_addr(cir_pkg::node_idx(node_reg),
                                                cir_pkg::node_idx(b_reg));
                state_next  = S_M2;
            end
            S_M2:
            begin
                ctl.load_sum = 1'b1;
                ctl.raddr    = cir_pkg::mat_addr(cir_pkg::node_idx(a_reg),
                                                 cir_pkg::node_idx(b_reg));
                state_next   = S_M3;
            end
            S_M3:
            begin
                // Score this edge, then advance or start the shift
                ctl.eval = 1'b1;
                if (cir_pkg::CNT_W'(idx_reg) + cir_pkg::CNT_W'(2) == count_reg)
                begin
                    j_next          = count_reg;
                    pend_valid_next = 1'b0;
                    state_next      = S_SHIFT;
                end
                else
                begin
                    a_next     = b_reg;
                    idx_next   = idx_reg + cir_pkg::ROUTE_AW'(1);
                    rt_raddr   = idx_reg + cir_pkg::ROUTE_AW'(2);
                    state_next = S_M0;
                end
            end
            S_SHIFT:
            begin
                // Move route[j-1] up to route[j], one entry per cycle
                if (j_reg > cir_pkg::CNT_W'(best_pos))
                begin
                    rt_raddr        = cir_pkg::ROUTE_AW'(j_reg - cir_pkg::CNT_W'(1));
                    pend_valid_next = 1'b1;
                    pend_addr_next  = cir_pkg::ROUTE_AW'(j_reg);
                    j_next          = j_reg - cir_pkg::CNT_W'(1);
                end
                else
                begin
                    pend_valid_next = 1'b0;
                    state_next      = S_PLACE;
                end
            end
            S_PLACE:
            begin
                rt_we      = 1'b1;
                rt_waddr   = best_pos;
                rt_wdata   = node_reg;
                count_next = count_reg + cir_pkg::CNT_W'(1);
                state_next = S_RESP;
            end
            S_RESP:
            begin
                // Load the result once the output register is free
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = stat_reg;
                    res_pos_next    = cir_pkg::POS_W'(best_pos);
                    res_cost_next   = cir_pkg::sat_cost(best);
                    res_len_next    = cir_pkg::LEN_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        from_reg       <= from_next;
        to_reg         <= to_next;
        tval_reg       <= tval_next;
        node_reg       <= node_next;
        idx_reg        <= idx_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        j_reg          <= j_next;
        pend_addr_reg  <= pend_addr_next;
        stat_reg       <= stat_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_cost_reg   <= res_cost_next;
        res_len_reg    <= res_len_next;
    end

`ifndef NO_ASSERTIONS
    // Route never grows past its capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cir_pkg::CNT_W'(cir_pkg::MAX_ROUTE))
        else $error("route length beyond capacity");

    // Route length only steps up by one or drops to empty
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        ((count_reg == $past(count_reg) + cir_pkg::CNT_W'(1)) || (count_reg == '0)))
        else $error("route length changed by an illegal step");

    // An insert position lies inside the new route
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.position != '0)) |->
        ((res.status == cir_pkg::ST_DONE) &&
         ({1'b0, res.position} < res.route_length)))
        else $error("insert position outside route");

    // One command at a time: no accept right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("command accepted while busy");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the cheapest-insertion route unit.
module tb_top;

    localparam int     CYCLE_LIMIT = 1_000_000;
    localparam int     HOLD_CYCLES = 300;
    localparam longint COST_HI     = (longint'(1) <<< (cir_pkg::COST_W - 1)) - 1;
    localparam longint COST_LO     = -(longint'(1) <<< (cir_pkg::COST_W - 1));

    typedef logic [cir_pkg::TRAVEL_W-1:0] travel_t;

    typedef struct packed {
        cir_pkg::status_t                   status;
        logic [cir_pkg::POS_W-1:0]          position;
        logic signed [cir_pkg::COST_W-1:0]  cost_increase;
        logic [cir_pkg::LEN_W-1:0]          route_length;
    } route_result_t;

    logic clk = 1'b0;
    logic rst_n;

    cir_cmd_if cmd_ch();
    cir_res_if res_ch();

    cheapest_insertion_route_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    // Predicted state of the unit
    cir_pkg::time_t    travel [cir_pkg::MAT_DEPTH];
    cir_pkg::node_id_t route [$];
    route_result_t     pending [$];

    // Nodes whose matrix entries among each other are all written
    cir_pkg::node_id_t pool [$];
    bit                pooled [cir_pkg::MAX_NODES];

    bit  idle_on = 1'b1;
    int  hold_off = 0;
    int  mismatches = 0;
    int  beats_sent = 0;
    int  cycle_count = 0;

    always #5 clk = ~clk;

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= 40)
        begin
            $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        end
    endtask

    // Work out the result of one command beat and advance the predicted state
    function automatic route_result_t apply_command(input cir_pkg::action_t act,
                                                    input cir_pkg::node_id_t fr,
                                                    input cir_pkg::node_id_t to,
                                                    input travel_t tv,
                                                    input cir_pkg::node_id_t nd);
        route_result_t r;
        longint        best;
        longint        inc;
        int            best_pos;
        r        = '0;
        r.status = cir_pkg::ST_DONE;
        best     = 0;
        best_pos = 1;
        case (act)
            cir_pkg::ACT_WRITE:
            begin
                travel[{fr, to}] = tv;
            end
            cir_pkg::ACT_CLEAR:
            begin
                route.delete();
            end
            default:
            begin
                if (route.size() >= cir_pkg::MAX_ROUTE)
                begin
                    r.status = cir_pkg::ST_FULL;
                end
                else if (act == cir_pkg::ACT_APPEND)
                begin
                    route.insert(route.size(), nd);
                end
                else if (route.size() < 2)
                begin
                    r.status = cir_pkg::ST_SHORT;
                end
                else
                begin
                    // Scan every edge, keep the first strict minimum
                    for (int i = 0; i + 1 < route.size(); i++)
                    begin
                        inc = longint'({32'd0, travel[{route[i], nd}]})
                            + longint'({32'd0, travel[{nd, route[i + 1]}]})
                            - longint'({32'd0, travel[{route[i], route[i + 1]}]});
                        if (i == 0 || inc < best)
                        begin
                            best     = inc;
                            best_pos = i + 1;
                        end
                    end
                    if (best > COST_HI)
                    begin
                        best = COST_HI;
                    end
                    else if (best < COST_LO)
                    begin
                        best = COST_LO;
                    end
                    route.insert(best_pos, nd);
                    r.position      = cir_pkg::POS_W'(best_pos);
                    r.cost_increase = best[cir_pkg::COST_W-1:0];
                end
            end
        endcase
        r.route_length = cir_pkg::LEN_W'(route.size());
        return r;
    endfunction

    function automatic cir_pkg::node_id_t rand_node();
        return cir_pkg::node_id_t'($urandom_range(0, cir_pkg::MAX_NODES - 1));
    endfunction

    function automatic cir_pkg::node_id_t pool_node();
        return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    // Mix of extremes, small or coarse values that tie often, near-maximum and full-range values
    function automatic travel_t pick_travel_time();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return cir_pkg::TRAVEL_W'($urandom_range(0, 3) << 16);
            3: return cir_pkg::TRAVEL_W'($urandom_range(0, 255));
            4: return ~cir_pkg::TRAVEL_W'($urandom_range(0, 255));
            default: return cir_pkg::TRAVEL_W'($urandom);
        endcase
    endfunction

    // Drive one command beat from a falling edge; valid stays high on return
    task automatic send_beat(input cir_pkg::action_t act, input cir_pkg::node_id_t fr,
                             input cir_pkg::node_id_t to, input travel_t tv,
                             input cir_pkg::node_id_t nd);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.action      <= act;
        cmd_ch.from_node   <= fr;
        cmd_ch.to_node     <= to;
        cmd_ch.travel_time <= tv;
        cmd_ch.node        <= nd;
        do @(posedge clk); while (!cmd_ch.ready);
        pending.insert(pending.size(), apply_command(act, fr, to, tv, nd));
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic send_write(input cir_pkg::node_id_t fr, input cir_pkg::node_id_t to,
                              input travel_t tv);
        send_beat(cir_pkg::ACT_WRITE, fr, to, tv, rand_node());
    endtask

    task automatic send_route_op(input cir_pkg::action_t act, input cir_pkg::node_id_t nd);
        send_beat(act, rand_node(), rand_node(), cir_pkg::TRAVEL_W'($urandom), nd);
    endtask

    // Hold the sender until every expected result has come back
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        do @(negedge clk); while (pending.size() != 0);
    endtask

    // Write all matrix entries between a new node, itself and the pool
    task automatic enroll_node(input cir_pkg::node_id_t nd);
        send_write(nd, nd, pick_travel_time());
        foreach (pool[k])
        begin
            send_write(nd, pool[k], pick_travel_time());
            send_write(pool[k], nd, pick_travel_time());
        end
        pool.insert(pool.size(), nd);
        pooled[nd] = 1'b1;
    endtask

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        route_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected result beat", longint'(res_ch.status), -1);
            end
            else
            begin
                want = pending.pop_front();
                if (res_ch.status !== want.status)
                    report_mismatch("status", longint'(res_ch.status), longint'(want.status));
                if (res_ch.position !== want.position)
                    report_mismatch("position", longint'(res_ch.position),
                                    longint'(want.position));
                if (res_ch.cost_increase !== want.cost_increase)
                    report_mismatch("cost_increase", longint'(res_ch.cost_increase),
                                    longint'(want.cost_increase));
                if (res_ch.route_length !== want.route_length)
                    report_mismatch("route_length", longint'(res_ch.route_length),
                                    longint'(want.route_length));
            end
        end
    end

    // Result ready: long hold-off on request, random stall bursts otherwise while idle_on is set
    initial
    begin
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (hold_off - 1) @(negedge clk);
                hold_off = 0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge clk);
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Insert into an empty and a one-node route
    task automatic test_short_route();
        send_route_op(cir_pkg::ACT_INSERT, 6'd63);
        send_route_op(cir_pkg::ACT_APPEND, 6'd0);
        send_route_op(cir_pkg::ACT_INSERT, 6'd42);
        send_route_op(cir_pkg::ACT_CLEAR, rand_node());
        drain_results();
    endtask

    // Largest positive and most negative increase
    task automatic test_cost_extremes();
        send_write(6'd0, 6'd0, '0);
        send_write(6'd0, 6'd63, '1);
        send_write(6'd63, 6'd0, '1);
        send_write(6'd63, 6'd63, '0);
        send_route_op(cir_pkg::ACT_CLEAR, rand_node());
        send_route_op(cir_pkg::ACT_APPEND, 6'd0);
        send_route_op(cir_pkg::ACT_APPEND, 6'd0);
        send_route_op(cir_pkg::ACT_INSERT, 6'd63);
        send_write(6'd0, 6'd63, '0);
        send_write(6'd63, 6'd0, '0);
        send_write(6'd63, 6'd63, '1);
        send_route_op(cir_pkg::ACT_CLEAR, rand_node());
        send_route_op(cir_pkg::ACT_APPEND, 6'd63);
        send_route_op(cir_pkg::ACT_APPEND, 6'd63);
        send_route_op(cir_pkg::ACT_INSERT, 6'd0);
        pool.insert(pool.size(), 6'd0);
        pool.insert(pool.size(), 6'd63);
        pooled[0]  = 1'b1;
        pooled[63] = 1'b1;
        drain_results();
    endtask

    // Both route edges cost the same: the first one wins
    task automatic test_equal_costs();
        send_route_op(cir_pkg::ACT_INSERT, 6'd63);
        drain_results();
    endtask

    // Stall the result side long enough for the unit to stop taking commands
    task automatic test_backpressure();
        hold_off = HOLD_CYCLES;
        send_write(6'd0, 6'd0, pick_travel_time());
        send_route_op(cir_pkg::ACT_CLEAR, rand_node());
        repeat (3) send_route_op(cir_pkg::ACT_APPEND, pool_node());
        repeat (2) send_route_op(cir_pkg::ACT_INSERT, pool_node());
        drain_results();
    endtask

    // Fill the route to its last slot by insert, then get rejected
    task automatic test_full_route();
        send_route_op(cir_pkg::ACT_CLEAR, rand_node());
        while (route.size() < cir_pkg::MAX_ROUTE - 1)
            send_route_op(cir_pkg::ACT_APPEND, pool_node());
        send_route_op(cir_pkg::ACT_INSERT, pool_node());
        send_route_op(cir_pkg::ACT_APPEND, rand_node());
        send_route_op(cir_pkg::ACT_INSERT, rand_node());
        send_route_op(cir_pkg::ACT_CLEAR, rand_node());
        drain_results();
    endtask

    // Random routes over a growing node pool, with rewrites and clears
    task automatic test_random_routes(input int n_beats);
        int                start;
        int                cap;
        int                pick;
        cir_pkg::node_id_t nd;
        start = beats_sent;
        cap   = $urandom_range(2, 24);
        while (beats_sent - start < n_beats)
        begin
            if (beats_sent - start > n_beats * 4 / 5)
                idle_on = 1'b0;
            pick = $urandom_range(0, 99);
            if (pool.size() < 16 && (pool.size() < 4 || pick < 3))
            begin
                do nd = rand_node(); while (pooled[nd]);
                enroll_node(nd);
            end
            else if (pick < 8)
            begin
                send_write(pool_node(), pool_node(), pick_travel_time());
            end
            else if (pick < 12)
            begin
                send_write(rand_node(), rand_node(), pick_travel_time());
            end
            else if (pick < 16 || route.size() >= cap)
            begin
                send_route_op(cir_pkg::ACT_CLEAR, rand_node());
                cap = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(2, 24);
            end
            else if (pick < 50)
            begin
                send_route_op(cir_pkg::ACT_APPEND, pool_node());
            end
            else
            begin
                // any node is safe while the route is too short to scan
                nd = (route.size() < 2) ? rand_node() : pool_node();
                send_route_op(cir_pkg::ACT_INSERT, nd);
            end
        end
        drain_results();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.action      = cir_pkg::ACT_WRITE;
        cmd_ch.from_node   = '0;
        cmd_ch.to_node     = '0;
        cmd_ch.travel_time = '0;
        cmd_ch.node        = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_short_route();
        test_cost_extremes();
        test_equal_costs();
        test_backpressure();
        test_full_route();
        test_random_routes(460);

        // let any stray result beat show up
        repeat (40) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/cir_pkg.sv
sv/cir_if.sv
sv/cir_cost.sv
sv/cheapest_insertion_route_unit.sv
tb/tb_top.sv
